/* rtl/grp_pkg.sv */
// Shared types, constants and helpers of the guillotine rectangle packer.
`default_nettype none
package grp_pkg;

  localparam int MaxRects  = 64;
  localparam int CoordBits = 16;
  localparam int IdxW      = $clog2(MaxRects);
  localparam int CntW      = $clog2(MaxRects + 1);
  localparam int RefW      = 24;
  localparam logic [RefW-1:0] RefMax = {RefW{1'b1}};

  localparam logic [1:0] STATUS_PLACED = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;
  localparam logic [1:0] STATUS_BAD    = 2'd3;

  localparam logic CFG_CANVAS_W = 1'b0;
  localparam logic CFG_CANVAS_H = 1'b1;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  function automatic coord_t rect_key(rect_t r);
    rect_key = (r.x > r.y) ? r.x : r.y;
  endfunction

endpackage
`default_nettype wire

/* rtl/grp_div.sv */
// Restoring divider, one quotient bit per cycle, for the sheet cell counts.
`default_nettype none
module grp_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire grp_pkg::coord_t   dividend_i,
  input  wire grp_pkg::coord_t   divisor_i,
  output logic                   done_o,
  output grp_pkg::coord_t        quot_o
);

  localparam int StepW = $clog2(grp_pkg::CoordBits);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [StepW-1:0]              step_q, step_d;
  logic [grp_pkg::CoordBits:0]   rem_q, rem_d;
  grp_pkg::coord_t               quo_q, quo_d;
  grp_pkg::coord_t               div_q, div_d;
  logic [grp_pkg::CoordBits:0]   rem_sh;
  logic [grp_pkg::CoordBits:0]   diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    rem_sh = {rem_q[grp_pkg::CoordBits-1:0], quo_q[grp_pkg::CoordBits-1]};
    diff   = rem_sh - {1'b0, div_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[grp_pkg::CoordBits]) begin
        rem_d = diff;
        quo_d = {quo_q[grp_pkg::CoordBits-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[grp_pkg::CoordBits-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(grp_pkg::CoordBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

/* rtl/guillotine_rect_packer.sv */
// Guillotine first-fit rectangle packer: top level with sequencer and free list memory.
`default_nettype none
// Each item places one rectangle into a sorted list of free rectangles held in a
// 64-entry memory with one read and one write port, and yields one result. The block
// takes one item at a time and stalls its input while working. An item scans the free
// entries in order, moves the later entries down when the chosen entry is removed,
// moves larger entries up to make room for each inserted piece, and for a sheet runs
// two divisions in turn and a multiply; it may then wait for the output register to
// drain. The one read and one write port of the free list memory set the pace of the
// scan and of the moves. A result waiting in the output register does not block
// the acceptance of the next item, only its completion.
module guillotine_rect_packer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] rect_width_i,
  input  wire logic [15:0] rect_height_i,
  input  wire logic        is_sheet_i,
  input  wire logic [15:0] cell_width_i,
  input  wire logic [15:0] cell_height_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      place_x_o,
  output logic [15:0]      place_y_o,
  output logic [23:0]      first_ref_o,
  output logic [15:0]      extent_width_o,
  output logic [15:0]      extent_height_o,
  output logic [1:0]       status_o
);

  localparam int CW = grp_pkg::CntW;
  localparam int IW = grp_pkg::IdxW;
  localparam int RW = grp_pkg::RefW;
  localparam int KW = grp_pkg::CoordBits;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_START    = 5'd1;
  localparam logic [4:0] S_SCAN_RD  = 5'd2;
  localparam logic [4:0] S_SCAN_CHK = 5'd3;
  localparam logic [4:0] S_MV_RD    = 5'd4;
  localparam logic [4:0] S_MV_WR    = 5'd5;
  localparam logic [4:0] S_FOUND    = 5'd6;
  localparam logic [4:0] S_DIVA_GO  = 5'd7;
  localparam logic [4:0] S_DIVA_WT  = 5'd8;
  localparam logic [4:0] S_DIVB_GO  = 5'd9;
  localparam logic [4:0] S_DIVB_WT  = 5'd10;
  localparam logic [4:0] S_MUL      = 5'd11;
  localparam logic [4:0] S_PLACE    = 5'd12;
  localparam logic [4:0] S_INS_ST   = 5'd13;
  localparam logic [4:0] S_INS_RD   = 5'd14;
  localparam logic [4:0] S_INS_CHK  = 5'd15;
  localparam logic [4:0] S_FIN      = 5'd16;

  logic [4:0]        st_q, st_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              base_q, base_d;
  logic [RW-1:0]     ref_q, ref_d;
  grp_pkg::coord_t   extw_q, extw_d, exth_q, exth_d;
  grp_pkg::coord_t   canw_q, canh_q;

  grp_pkg::coord_t   rw_q, rh_q, cw_q, ch_q;
  logic              sheet_q;
  grp_pkg::rect_t    bin_q, bin_d, p0_q, p0_d, p1_q, p1_d;
  logic              sel_q, sel_d;
  logic [1:0]        stat_q, stat_d;
  grp_pkg::coord_t   px_q, px_d, py_q, py_d;
  logic [RW-1:0]     first_q, first_d;
  grp_pkg::coord_t   qa_q, qa_d;
  logic [2*KW-1:0]   prod_q, prod_d;

  logic              ov_q, ov_d;
  grp_pkg::coord_t   ox_q, oy_q, oew_q, oeh_q;
  logic [RW-1:0]     oref_q;
  logic [1:0]        ost_q;
  logic              out_load;

  grp_pkg::rect_t    mem_q [grp_pkg::MaxRects];
  grp_pkg::rect_t    rd_q;
  logic [IW-1:0]     rd_addr;
  logic              mem_we;
  logic [IW-1:0]     wr_addr;
  grp_pkg::rect_t    wr_data;

  logic              div_start;
  grp_pkg::coord_t   div_a, div_b, div_q;
  logic              div_done;

  grp_pkg::rect_t    piece;
  logic [RW+KW:0]    ref_sum;
  logic [2*KW-1:0]   add_v;
  grp_pkg::coord_t   ex_x, ex_y;
  logic              in_acc;

  grp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign in_stall_o = (st_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign piece      = sel_q ? p1_q : p0_q;
  assign add_v      = sheet_q ? prod_q : (2*KW)'(1);
  assign ref_sum    = (RW+KW+1)'(ref_q) + (RW+KW+1)'(add_v);
  assign ex_x       = bin_q.x + rw_q;
  assign ex_y       = bin_q.y + rh_q;

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    base_d    = base_q;
    ref_d     = ref_q;
    extw_d    = extw_q;
    exth_d    = exth_q;
    bin_d     = bin_q;
    p0_d      = p0_q;
    p1_d      = p1_q;
    sel_d     = sel_q;
    stat_d    = stat_q;
    px_d      = px_q;
    py_d      = py_q;
    first_d   = first_q;
    qa_d      = qa_q;
    prod_d    = prod_q;
    rd_addr   = idx_q[IW-1:0];
    mem_we    = 1'b0;
    wr_addr   = idx_q[IW-1:0];
    wr_data   = piece;
    div_start = 1'b0;
    div_a     = rw_q;
    div_b     = cw_q;
    out_load  = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          st_d = S_START;
        end
      end
      S_START: begin
        stat_d  = grp_pkg::STATUS_PLACED;
        px_d    = '0;
        py_d    = '0;
        first_d = ref_q;
        idx_d   = '0;
        if (sheet_q && (cw_q == '0 || ch_q == '0)) begin
          stat_d = grp_pkg::STATUS_BAD;
          st_d   = S_FIN;
        end else if (base_q) begin
          if (canw_q >= rw_q && canh_q >= rh_q) begin
            bin_d  = '{x: '0, y: '0, w: canw_q, h: canh_q};
            base_d = 1'b0;
            st_d   = S_FOUND;
          end else begin
            stat_d = grp_pkg::STATUS_NO_FIT;
            st_d   = S_FIN;
          end
        end else if (cnt_q == '0) begin
          stat_d = grp_pkg::STATUS_NO_FIT;
          st_d   = S_FIN;
        end else begin
          st_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        st_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rd_q.w >= rw_q && rd_q.h >= rh_q) begin
          bin_d = rd_q;
          st_d  = S_MV_RD;
        end else if (idx_q + 1'b1 == cnt_q) begin
          stat_d = grp_pkg::STATUS_NO_FIT;
          st_d   = S_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
          st_d  = S_SCAN_RD;
        end
      end
      // Close the gap left by the taken entry, moving each later entry down by one.
      S_MV_RD: begin
        rd_addr = IW'(idx_q + 1'b1);
        if (idx_q + 1'b1 >= cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          st_d  = S_FOUND;
        end else begin
          st_d = S_MV_WR;
        end
      end
      S_MV_WR: begin
        mem_we  = 1'b1;
        wr_data = rd_q;
        idx_d   = idx_q + 1'b1;
        st_d    = S_MV_RD;
      end
      S_FOUND: begin
        st_d = sheet_q ? S_DIVA_GO : S_PLACE;
      end
      S_DIVA_GO: begin
        div_start = 1'b1;
        st_d      = S_DIVA_WT;
      end
      S_DIVA_WT: begin
        if (div_done) begin
          qa_d = div_q;
          st_d = S_DIVB_GO;
        end
      end
      S_DIVB_GO: begin
        div_start = 1'b1;
        div_a     = rh_q;
        div_b     = ch_q;
        st_d      = S_DIVB_WT;
      end
      S_DIVB_WT: begin
        if (div_done) begin
          prod_d = {{KW{1'b0}}, div_q};
          st_d   = S_MUL;
        end
      end
      S_MUL: begin
        prod_d = qa_q * prod_q[KW-1:0];
        st_d   = S_PLACE;
      end
      S_PLACE: begin
        px_d  = bin_q.x;
        py_d  = bin_q.y;
        ref_d = (ref_sum > (RW+KW+1)'(grp_pkg::RefMax)) ? grp_pkg::RefMax
                                                         : ref_sum[RW-1:0];
        if (ex_x > extw_q) begin
          extw_d = ex_x;
        end
        if (ex_y > exth_q) begin
          exth_d = ex_y;
        end
        if (bin_q.w < bin_q.h) begin
          p0_d = '{x: ex_x, y: bin_q.y, w: bin_q.w - rw_q, h: rh_q};
          p1_d = '{x: bin_q.x, y: ex_y, w: bin_q.w, h: bin_q.h - rh_q};
        end else begin
          p0_d = '{x: bin_q.x, y: ex_y, w: rw_q, h: bin_q.h - rh_q};
          p1_d = '{x: ex_x, y: bin_q.y, w: bin_q.w - rw_q, h: bin_q.h};
        end
        sel_d = 1'b0;
        st_d  = S_INS_ST;
      end
      S_INS_ST: begin
        idx_d = cnt_q;
        if (piece.w == '0 || piece.h == '0 ||
            cnt_q >= CW'(grp_pkg::MaxRects)) begin
          if (piece.w != '0 && piece.h != '0) begin
            stat_d = grp_pkg::STATUS_FULL;
          end
          sel_d = 1'b1;
          st_d  = sel_q ? S_FIN : S_INS_ST;
        end else begin
          st_d = S_INS_RD;
        end
      end
      // Walk down from the end, moving larger keys up until the slot is found.
      S_INS_RD: begin
        rd_addr = IW'(idx_q - 1'b1);
        if (idx_q == '0) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          sel_d  = 1'b1;
          st_d   = sel_q ? S_FIN : S_INS_ST;
        end else begin
          st_d = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        mem_we = 1'b1;
        if (grp_pkg::rect_key(rd_q) > grp_pkg::rect_key(piece)) begin
          wr_data = rd_q;
          idx_d   = idx_q - 1'b1;
          st_d    = S_INS_RD;
        end else begin
          cnt_d = cnt_q + 1'b1;
          sel_d = 1'b1;
          st_d  = sel_q ? S_FIN : S_INS_ST;
        end
      end
      S_FIN: begin
        if (!ov_q || !out_stall_i) begin
          out_load = 1'b1;
          st_d     = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (out_load) begin
      ov_d = 1'b1;
    end else if (!out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      idx_q  <= '0;
      base_q <= 1'b1;
      ref_q  <= '0;
      extw_q <= '0;
      exth_q <= '0;
      canw_q <= '1;
      canh_q <= '1;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      base_q <= base_d;
      ref_q  <= ref_d;
      extw_q <= extw_d;
      exth_q <= exth_d;
      ov_q   <= ov_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          grp_pkg::CFG_CANVAS_W: canw_q <= cfg_data_i;
          grp_pkg::CFG_CANVAS_H: canh_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rw_q    <= rect_width_i;
      rh_q    <= rect_height_i;
      sheet_q <= is_sheet_i;
      cw_q    <= cell_width_i;
      ch_q    <= cell_height_i;
    end
    bin_q   <= bin_d;
    p0_q    <= p0_d;
    p1_q    <= p1_d;
    sel_q   <= sel_d;
    stat_q  <= stat_d;
    px_q    <= px_d;
    py_q    <= py_d;
    first_q <= first_d;
    qa_q    <= qa_d;
    prod_q  <= prod_d;
    if (out_load) begin
      ox_q   <= px_q;
      oy_q   <= py_q;
      oref_q <= first_q;
      oew_q  <= extw_q;
      oeh_q  <= exth_q;
      ost_q  <= stat_q;
    end
  end

  assign out_valid_o     = ov_q;
  assign place_x_o       = ox_q;
  assign place_y_o       = oy_q;
  assign first_ref_o     = oref_q;
  assign extent_width_o  = oew_q;
  assign extent_height_o = oeh_q;
  assign status_o        = ost_q;

endmodule
`default_nettype wire

/* test/guillotine_rect_packer_tb.sv */
// Self-checking testbench of the guillotine first-fit rectangle packer.
`default_nettype none
module guillotine_rect_packer_tb;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] h;
    logic        sheet;
    logic [15:0] cw;
    logic [15:0] ch;
  } request_t;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [23:0] ref_idx;
    logic [15:0] ext_w;
    logic [15:0] ext_h;
    logic [1:0]  status;
  } placement_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] rect_width_i = '0;
  logic [15:0] rect_height_i = '0;
  logic is_sheet_i = 1'b0;
  logic [15:0] cell_width_i = '0;
  logic [15:0] cell_height_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] place_x_o, place_y_o, extent_width_o, extent_height_o;
  logic [23:0] first_ref_o;
  logic [1:0] status_o;

  guillotine_rect_packer i_dut (.*);

  always #4 clk_i = ~clk_i;

  // Predictor state.
  logic [15:0]     canvas_w, canvas_h;
  grp_pkg::rect_t  free_list[$];
  logic            canvas_unused;
  logic [23:0]     ref_next;
  logic [15:0]     ext_w, ext_h;

  request_t   pending_reqs[$];
  placement_t expected_places[$];
  int errors = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit add_free(grp_pkg::rect_t r);
    int pos;
    pos = 0;
    if (free_list.size() >= grp_pkg::MaxRects) return 1'b0;
    while (pos < free_list.size() &&
           ((free_list[pos].x > free_list[pos].y) ? free_list[pos].x : free_list[pos].y)
           <= ((r.x > r.y) ? r.x : r.y))
      pos++;
    free_list.insert(pos, r);
    return 1'b1;
  endfunction

  function automatic placement_t pack_predict(request_t q);
    placement_t res;
    grp_pkg::rect_t bin, p0, p1;
    bit found;
    logic [47:0] sum;
    logic [16:0] ex;
    found = 1'b0;
    res = '0;
    res.ref_idx = ref_next;
    if (q.sheet && (q.cw == 0 || q.ch == 0)) begin
      res.status = grp_pkg::STATUS_BAD;
    end else begin
      if (canvas_unused) begin
        bin = '{x: 16'd0, y: 16'd0, w: canvas_w, h: canvas_h};
        if (bin.w >= q.w && bin.h >= q.h) begin
          found = 1'b1;
          canvas_unused = 1'b0;
        end
      end else begin
        foreach (free_list[i]) begin
          if (!found && free_list[i].w >= q.w && free_list[i].h >= q.h) begin
            bin = free_list[i];
            free_list.delete(i);
            found = 1'b1;
            break;
          end
        end
      end
      if (!found) begin
        res.status = grp_pkg::STATUS_NO_FIT;
      end else begin
        res.status = grp_pkg::STATUS_PLACED;
        res.px = bin.x;
        res.py = bin.y;
        sum = q.sheet ? 48'(q.w / q.cw) * 48'(q.h / q.ch) : 48'd1;
        sum = sum + ref_next;
        ref_next = (sum > grp_pkg::RefMax) ? grp_pkg::RefMax : sum[23:0];
        ex = bin.x + q.w;
        if (ex > ext_w) ext_w = ex[15:0];
        ex = bin.y + q.h;
        if (ex > ext_h) ext_h = ex[15:0];
        if (bin.w < bin.h) begin
          p0 = '{x: bin.x + q.w, y: bin.y, w: bin.w - q.w, h: q.h};
          p1 = '{x: bin.x, y: bin.y + q.h, w: bin.w, h: bin.h - q.h};
        end else begin
          p0 = '{x: bin.x, y: bin.y + q.h, w: q.w, h: bin.h - q.h};
          p1 = '{x: bin.x + q.w, y: bin.y, w: bin.w - q.w, h: bin.h};
        end
        if (p0.w != 0 && p0.h != 0 && !add_free(p0)) res.status = grp_pkg::STATUS_FULL;
        if (p1.w != 0 && p1.h != 0 && !add_free(p1)) res.status = grp_pkg::STATUS_FULL;
      end
    end
    res.ext_w = ext_w;
    res.ext_h = ext_h;
    return res;
  endfunction

  // Driver: one item at a time from the pending queue, random gap before each.
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_places.push_back(pack_predict(pending_reqs.pop_front()));
      in_gap = $urandom_range(0, 6);
    end
    if ((in_valid_i && !in_stall_o) || !in_valid_i) begin
      if (in_gap > 0 || pending_reqs.size() == 0 || !rst_ni) begin
        in_valid_i <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        in_valid_i    <= 1'b1;
        rect_width_i  <= pending_reqs[0].w;
        rect_height_i <= pending_reqs[0].h;
        is_sheet_i    <= pending_reqs[0].sheet;
        cell_width_i  <= pending_reqs[0].cw;
        cell_height_i <= pending_reqs[0].ch;
      end
    end
  end

  // Monitor: checks each accepted result and draws a stall for the next.
  int out_wait = 0;
  always @(posedge clk_i) begin
    placement_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_places.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        e = expected_places.pop_front();
        if (place_x_o !== e.px) report("place_x", place_x_o, e.px);
        if (place_y_o !== e.py) report("place_y", place_y_o, e.py);
        if (first_ref_o !== e.ref_idx) report("first_ref", first_ref_o, e.ref_idx);
        if (extent_width_o !== e.ext_w) report("extent_width", extent_width_o, e.ext_w);
        if (extent_height_o !== e.ext_h) report("extent_height", extent_height_o, e.ext_h);
        if (status_o !== e.status) report("status", status_o, e.status);
      end
      out_wait = $urandom_range(0, 6);
    end
    if (out_wait > 0) begin
      out_stall_i <= 1'b1;
      out_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic write_canvas(input logic [15:0] w, input logic [15:0] h);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= grp_pkg::CFG_CANVAS_W;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_index_i <= grp_pkg::CFG_CANVAS_H;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    canvas_w = w;
    canvas_h = h;
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_places.size() == 0);
    repeat (700) @(posedge clk_i);
  endtask

  function automatic request_t random_req(int span);
    request_t q;
    q.w = 16'($urandom_range(0, span));
    q.h = 16'($urandom_range(0, span));
    q.sheet = $urandom_range(0, 3) == 0;
    q.cw = $urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom_range(1, 12));
    q.ch = $urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom_range(1, 12));
    if ($urandom_range(0, 19) == 0) q.w = 16'($urandom);
    if ($urandom_range(0, 19) == 0) q.h = 16'($urandom);
    if ($urandom_range(0, 19) == 0) q.cw = 16'($urandom);
    if ($urandom_range(0, 19) == 0) q.ch = 16'($urandom);
    return q;
  endfunction

  // Reset state of the canvas and the list; the DUT keeps its list across phases,
  // so only the register values change between phases.
  initial begin
    int span;
    canvas_w = 16'hFFFF;
    canvas_h = 16'hFFFF;
    canvas_unused = 1'b1;
    ref_next = '0;
    ext_w = '0;
    ext_h = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, sheets, bad cells, zero sizes, no fit, large sheet counts.
    pending_reqs.push_back('{16'd0, 16'd0, 1'b0, 16'd0, 16'd0});
    pending_reqs.push_back('{16'd10, 16'd20, 1'b0, 16'd0, 16'd0});
    pending_reqs.push_back('{16'd10, 16'd20, 1'b1, 16'd0, 16'd5});
    pending_reqs.push_back('{16'd10, 16'd20, 1'b1, 16'd5, 16'd0});
    pending_reqs.push_back('{16'd30, 16'd40, 1'b1, 16'd7, 16'd9});
    pending_reqs.push_back('{16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0});
    pending_reqs.push_back('{16'h8000, 16'h4000, 1'b1, 16'd1, 16'd1});
    pending_reqs.push_back('{16'h4000, 16'h8000, 1'b1, 16'd1, 16'd1});
    pending_reqs.push_back('{16'h2000, 16'h2000, 1'b1, 16'hFFFF, 16'hFFFF});
    pending_reqs.push_back('{16'd5, 16'd0, 1'b0, 16'hFFFF, 16'hFFFF});
    pending_reqs.push_back('{16'd0, 16'd5, 1'b1, 16'd3, 16'd3});
    drain();

    // Phases at different canvas sizes; the later canvas settings are not used by
    // the DUT once its canvas is taken, and the directed items above already take the full reset canvas.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_canvas(16'hFFFF, 16'hFFFF);
        1: write_canvas(16'd1, 16'd1);
        2: write_canvas(16'd0, 16'd0);
        3: write_canvas(16'd300, 16'd200);
        default: write_canvas(16'($urandom), 16'($urandom));
      endcase
      span = (ph == 0) ? 2000 : 600;
      for (int n = 0; n < 260; n++) pending_reqs.push_back(random_req(span));
      drain();
    end
    if (errors == 0) begin
      $display("guillotine_rect_packer_tb passed");
    end else begin
      $display("guillotine_rect_packer_tb failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("guillotine_rect_packer_tb failed");
    $finish;
  end
endmodule
`default_nettype wire
